>>> rtl/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and helpers of the tab to space expander.
// ----------------------------------------------------------------------------
package tte_pkg;

  // character codes
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] PrintLo = 8'h20;
  localparam logic [7:0] PrintHi = 8'h7E;

  localparam int ColumnBitsDef = 12;
  localparam int NumStops      = 6;
  localparam int MaxStops      = 6;
  localparam int StopW         = 7;
  localparam int CountW        = 3;
  localparam int RunW          = 7;
  localparam int ModW          = 6;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 7;
  localparam int FifoDepth     = 2;

  localparam logic [StopW-1:0] StopLimit = 7'd64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStopCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStopA     = 3'd1;

  typedef logic [StopW-1:0] stop_t;
  typedef stop_t [NumStops-1:0] stop_arr_t;

  localparam stop_arr_t StopReset = {7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } tte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } tte_out_t;

  // one queued command: the byte and how many beats it gives
  typedef struct packed {
    logic [7:0]      out_byte;
    logic [RunW-1:0] run;
  } tte_cmd_t;

  // zero reads as one, anything above the limit as the limit
  function automatic stop_t eff_stop(input stop_t s);
    stop_t r;
    r = s;
    if (s == '0) begin
      r = 7'd1;
    end else if (s > StopLimit) begin
      r = StopLimit;
    end
    return r;
  endfunction

endpackage

>>> rtl/tte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_fifo
// Short command queue between the classifier and the beat generator.
// ----------------------------------------------------------------------------
module tte_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tte_pkg::tte_cmd_t push_data_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output tte_pkg::tte_cmd_t pop_data_o
);
  import tte_pkg::*;

  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);

  tte_cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && push_ready_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (!do_push && do_pop) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/tte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_front
// Holds the stop registers and the column, classifies each input byte and
// works out its beat count; keeps column mod width with a remainder unit.
// ----------------------------------------------------------------------------
module tte_front #(
  parameter int COLUMN_BITS = tte_pkg::ColumnBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tte_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tte_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tte_pkg::tte_in_t              in_data_i,
  output logic                          cmd_push_o,
  output tte_pkg::tte_cmd_t             cmd_o,
  input  logic                          cmd_ready_i
);
  import tte_pkg::*;

  localparam logic [COLUMN_BITS-1:0] ColMax = '1;
  localparam int DivCntW = $clog2(COLUMN_BITS);

  logic [CountW-1:0]      count_q;
  stop_arr_t              stop_q;
  logic [COLUMN_BITS-1:0] column_q, column_d;
  logic [ModW-1:0]        mod_q, mod_d;
  logic                   mod_ok_q, mod_ok_d;
  logic                   div_run_q;
  logic [DivCntW-1:0]     div_cnt_q;
  logic [ModW-1:0]        rem_q;

  logic [CountW-1:0]      eff_cnt;
  stop_t                  width;
  stop_arr_t              eff;
  logic                   mode_eight, mode_uniform;
  logic                   accept;
  logic [COLUMN_BITS-1:0] col0;
  logic [ModW-1:0]        mod0;
  logic                   mod_ok0;
  logic [RunW-1:0]        run, list_run;
  logic                   list_hit;
  logic [COLUMN_BITS:0]   sum;
  logic [StopW-1:0]       rem_sh;
  logic [ModW-1:0]        rem_next;
  logic [7:0]             b;

  always_comb begin
    for (int i = 0; i < NumStops; i++) begin
      eff[i] = eff_stop(stop_q[i]);
    end
  end

  assign eff_cnt      = (count_q > CountW'(MaxStops)) ? CountW'(MaxStops) : count_q;
  assign width        = eff[0];
  assign mode_eight   = (eff_cnt == '0);
  assign mode_uniform = (eff_cnt == CountW'(1));

  // uniform mode needs a valid remainder before a byte may enter
  assign in_ready_o = cmd_ready_i && !(mode_uniform && !mod_ok_q);
  assign accept     = in_valid_i && in_ready_o;

  assign b       = in_data_i.in_byte;
  assign col0    = in_data_i.new_file ? '0 : column_q;
  assign mod0    = in_data_i.new_file ? '0 : mod_q;
  assign mod_ok0 = in_data_i.new_file ? 1'b1 : mod_ok_q;

  // first listed stop beyond the column
  always_comb begin
    list_hit = 1'b0;
    list_run = RunW'(1);
    for (int i = 0; i < NumStops; i++) begin
      if (!list_hit && (CountW'(i) < eff_cnt) && (COLUMN_BITS'(eff[i]) > col0)) begin
        list_hit = 1'b1;
        list_run = RunW'(COLUMN_BITS'(eff[i]) - col0);
      end
    end
  end

  always_comb begin
    if (col0 == ColMax) begin
      run = RunW'(1);
    end else if (mode_eight) begin
      run = RunW'(4'd8 - {1'b0, col0[2:0]});
    end else if (mode_uniform) begin
      run = RunW'(width - {1'b0, mod0});
    end else begin
      run = list_run;
    end
  end

  assign sum = {1'b0, col0} + (COLUMN_BITS + 1)'(run);

  assign cmd_push_o     = accept;
  assign cmd_o.out_byte = (b == ChTab) ? ChSpace : b;
  assign cmd_o.run      = (b == ChTab) ? run : RunW'(1);

  // remainder step, column bits msb first
  assign rem_sh   = {rem_q, column_q[div_cnt_q]};
  assign rem_next = (rem_sh >= width) ? ModW'(rem_sh - width) : ModW'(rem_sh);

  always_comb begin
    column_d = column_q;
    mod_d    = mod_q;
    mod_ok_d = mod_ok_q;
    if (accept) begin
      column_d = col0;
      mod_d    = mod0;
      mod_ok_d = mod_ok0;
      if (b == ChTab) begin
        if (col0 != ColMax) begin
          if (sum > (COLUMN_BITS + 1)'(ColMax)) begin
            column_d = ColMax;
            mod_ok_d = 1'b0;
          end else begin
            column_d = sum[COLUMN_BITS-1:0];
            if (mode_uniform) begin
              mod_d = '0;
            end else begin
              mod_ok_d = 1'b0;
            end
          end
        end
      end else if (b == ChBs) begin
        if (col0 != '0) begin
          column_d = col0 - 1'b1;
          mod_d    = (mod0 == '0) ? ModW'(width - 1'b1) : ModW'(mod0 - 1'b1);
        end
      end else if (b == ChNl) begin
        column_d = '0;
        mod_d    = '0;
        mod_ok_d = 1'b1;
      end else if (b >= PrintLo && b <= PrintHi) begin
        if (col0 != ColMax) begin
          column_d = col0 + 1'b1;
          mod_d    = ({1'b0, mod0} + 1'b1 == width) ? '0 : ModW'(mod0 + 1'b1);
        end
      end
    end
    if (cfg_we_i) begin
      // width may have moved: redo the remainder
      mod_ok_d = 1'b0;
    end else if (div_run_q && (div_cnt_q == '0)) begin
      mod_d    = rem_next;
      mod_ok_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      stop_q    <= StopReset;
      column_q  <= '0;
      mod_q     <= '0;
      mod_ok_q  <= 1'b1;
      div_run_q <= 1'b0;
      div_cnt_q <= '0;
      rem_q     <= '0;
    end else begin
      column_q <= column_d;
      mod_q    <= mod_d;
      mod_ok_q <= mod_ok_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStopCount) begin
          count_q <= cfg_data_i[CountW-1:0];
        end
        for (int i = 0; i < NumStops; i++) begin
          if (cfg_idx_i == CfgIdxW'(RegStopA + i)) begin
            stop_q[i] <= cfg_data_i[StopW-1:0];
          end
        end
        div_run_q <= 1'b0;
      end else if (div_run_q) begin
        rem_q     <= rem_next;
        div_cnt_q <= DivCntW'(div_cnt_q - 1'b1);
        if (div_cnt_q == '0) begin
          div_run_q <= 1'b0;
        end
      end else if (!mod_ok_q && mode_uniform) begin
        div_run_q <= 1'b1;
        div_cnt_q <= DivCntW'(COLUMN_BITS - 1);
        rem_q     <= '0;
      end
    end
  end

endmodule

>>> rtl/tte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_back
// Takes queued commands and plays each out as a run of output beats
// through a registered output stage.
// ----------------------------------------------------------------------------
module tte_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  tte_pkg::tte_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tte_pkg::tte_out_t out_data_o
);
  import tte_pkg::*;

  logic            busy_q;
  logic [RunW-1:0] remain_q;
  logic [7:0]      byte_q;
  logic            out_valid_q;
  tte_out_t        out_q;
  logic            adv;

  assign adv         = !out_valid_q || out_ready_i;
  assign cmd_pop_o   = adv && !busy_q && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (busy_q) begin
        out_valid_q <= 1'b1;
        remain_q    <= RunW'(remain_q - 1'b1);
        if (remain_q == RunW'(1)) begin
          busy_q <= 1'b0;
        end
      end else if (cmd_valid_i) begin
        out_valid_q <= 1'b1;
        if (cmd_i.run != RunW'(1)) begin
          busy_q   <= 1'b1;
          remain_q <= RunW'(cmd_i.run - 1'b1);
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (busy_q) begin
        out_q.out_byte <= byte_q;
        out_q.last     <= (remain_q == RunW'(1));
      end else if (cmd_valid_i) begin
        byte_q         <= cmd_i.out_byte;
        out_q.out_byte <= cmd_i.out_byte;
        out_q.last     <= (cmd_i.run == RunW'(1));
      end
    end
  end

endmodule

>>> rtl/tab_to_space_expander.sv
`timescale 1ns / 1ps
// path: an accepted byte is written into the command queue, then registered in the output stage as its first beat
// throughput: one beat per cycle while out_ready_i is high; a non-tab byte gives one beat, a tab
//   gives one beat per space emitted, played out by the beat generator
// uniform width mode: after a config write or a tab that saturates the
//   column, input is held off until the remainder unit has redone column mod width
// reset: asynchronous, stops return to 8..48, count and column to zero
// ----------------------------------------------------------------------------
// tab_to_space_expander
// Text byte stream in, tabs expanded to spaces out, with a column tracker
// and three tab stop modes.
// ----------------------------------------------------------------------------
module tab_to_space_expander #(
  parameter int COLUMN_BITS = tte_pkg::ColumnBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tte_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tte_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tte_pkg::tte_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tte_pkg::tte_out_t             out_data_o
);
  import tte_pkg::*;

  logic     push, push_ready, pop, pop_valid;
  tte_cmd_t push_cmd, pop_cmd;

  tte_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_push_o (push),
    .cmd_o      (push_cmd),
    .cmd_ready_i(push_ready)
  );

  tte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_cmd)
  );

  tte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(pop_valid),
    .cmd_i      (pop_cmd),
    .cmd_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tab to space expander. A short list of probe
// bytes runs first, several with hand-worked beat counts. It is followed by
// random byte streams under a series of tab stop settings, including column
// saturation, clamped stop values and unordered stop lists. Every output beat
// is compared against the hand-worked count or else an in-bench column tracker.
// ----------------------------------------------------------------------------
module tb;
  import tte_pkg::*;

  localparam int ColBits   = ColumnBitsDef;
  localparam int ColMax    = (1 << ColBits) - 1;
  localparam int DefTabW   = 8;
  localparam int HoldLen   = 200;
  localparam int SettleCyc = 6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
    logic [7:0] out_byte;
    logic [6:0] beats;  // zero: take the tracker's answer
  } probe_row_t;

  localparam int NumProbes = 20;
  localparam probe_row_t ProbeRows [NumProbes] = '{
    '{ChTab,   1'b1, ChSpace, 7'd8},
    '{8'h41,   1'b0, 8'h41,   7'd1},
    '{ChTab,   1'b0, ChSpace, 7'd7},
    '{ChBs,    1'b0, ChBs,    7'd1},
    '{ChTab,   1'b0, ChSpace, 7'd1},
    '{ChNl,    1'b0, ChNl,    7'd1},
    '{ChBs,    1'b0, ChBs,    7'd1},
    '{ChTab,   1'b0, ChSpace, 7'd8},
    '{8'h00,   1'b0, 8'h00,   7'd1},
    '{8'hFF,   1'b0, 8'hFF,   7'd1},
    '{8'h7F,   1'b0, 8'h7F,   7'd1},
    '{8'h7E,   1'b0, 8'h7E,   7'd1},
    '{8'h20,   1'b0, 8'h20,   7'd1},
    '{8'h1F,   1'b0, 8'h1F,   7'd1},
    '{8'h80,   1'b0, 8'h80,   7'd1},
    '{ChTab,   1'b0, ChSpace, 7'd6},
    '{8'h7E,   1'b1, 8'h7E,   7'd1},
    '{ChTab,   1'b0, ChSpace, 7'd0},
    '{8'h7A,   1'b0, 8'h7A,   7'd0},
    '{ChTab,   1'b1, ChSpace, 7'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tte_in_t             in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tte_out_t            out_data;

  // column tracker state and register mirror
  logic [ColBits-1:0]  col = '0;
  logic [CountW-1:0]   cfg_count = '0;
  stop_arr_t           cfg_stops = StopReset;

  tte_out_t            beats_due[$];
  int unsigned         n_errors = 0;
  logic                no_idle = 1'b0;
  logic                hold_req = 1'b0;

  tab_to_space_expander #(
    .COLUMN_BITS(ColBits)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("tab_to_space_expander test failed");
    $finish;
  end

  function automatic int unsigned stop_col(input int unsigned i);
    int unsigned s;
    s = cfg_stops[i];
    if (s == 0) begin
      s = 1;
    end else if (s > StopLimit) begin
      s = StopLimit;
    end
    return s;
  endfunction

  // spaces a tab gives at the current column
  function automatic int unsigned tab_run();
    int unsigned cnt;
    int unsigned w;
    int unsigned i;
    if (col == ColMax) begin
      return 1;
    end
    cnt = (cfg_count > MaxStops) ? MaxStops : cfg_count;
    if (cnt == 0) begin
      return DefTabW - col[2:0];
    end
    if (cnt == 1) begin
      w = stop_col(0);
      return w - (col % w);
    end
    for (i = 0; i < cnt; i++) begin
      if (stop_col(i) > col) begin
        return stop_col(i) - col;
      end
    end
    return 1;
  endfunction

  function automatic void bump_col(input int unsigned n);
    int unsigned sum;
    sum = col + n;
    col = (sum > ColMax) ? ColMax[ColBits-1:0] : sum[ColBits-1:0];
  endfunction

  // advance the column for one byte; returns the beat count and fill byte
  function automatic int unsigned expand_byte(input tte_in_t it, output logic [7:0] fill);
    int unsigned n;
    if (it.new_file) begin
      col = '0;
    end
    fill = it.in_byte;
    n = 1;
    if (it.in_byte == ChTab) begin
      fill = ChSpace;
      n = tab_run();
      bump_col(n);
    end else if (it.in_byte == ChBs) begin
      if (col != 0) begin
        col = col - 1'b1;
      end
    end else if (it.in_byte == ChNl) begin
      col = '0;
    end else if (it.in_byte >= PrintLo && it.in_byte <= PrintHi) begin
      bump_col(1);
    end
    return n;
  endfunction

  function automatic tte_in_t rand_byte();
    tte_in_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.in_byte = ChTab;
    end else if (pick < 38) begin
      it.in_byte = ChNl;
    end else if (pick < 44) begin
      it.in_byte = ChBs;
    end else if (pick < 82) begin
      it.in_byte = 8'($urandom_range(PrintLo, PrintHi));
    end else begin
      it.in_byte = 8'($urandom_range(0, 255));
    end
    it.new_file = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  // offer one byte, then queue the beats it should give once accepted
  task automatic send_byte(input tte_in_t it, input logic [7:0] hand_fill,
                           input int unsigned hand_n);
    int unsigned gap;
    int unsigned n;
    int unsigned k;
    logic [7:0] fill;
    tte_out_t beat;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n = expand_byte(it, fill);
    if (hand_n != 0) begin
      n = hand_n;
      fill = hand_fill;
    end
    for (k = 0; k < n; k++) begin
      beat.out_byte = fill;
      beat.last     = (k + 1 == n);
      beats_due.push_back(beat);
    end
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      send_byte(rand_byte(), 8'h00, 0);
    end
  endtask

  // stop offering and wait out every pending beat
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == RegStopCount) begin
      cfg_count = val[CountW-1:0];
    end else begin
      cfg_stops[idx - RegStopA] = val;
    end
  endtask

  task automatic load_stops(input logic [CountW-1:0] cnt, input stop_arr_t s);
    int unsigned i;
    drain();
    // upper data bits are don't-care for the count register
    write_reg(RegStopCount, {4'($urandom_range(0, 15)), cnt});
    for (i = 0; i < NumStops; i++) begin
      write_reg(RegStopA + CfgIdxW'(i), s[i]);
    end
    cfg_we <= 1'b0;
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic stop_arr_t rand_stops();
    stop_arr_t s;
    int unsigned i;
    for (i = 0; i < NumStops; i++) begin
      s[i] = 7'($urandom_range(0, 127));
    end
    return s;
  endfunction

  // output side: random stalls per beat, long hold-off on request
  initial begin : beat_sink
    int unsigned stall_left;
    int unsigned hold_left;
    logic hold_seen;
    tte_out_t want;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat byte=%h last=%b", $time,
                   out_data.out_byte, out_data.last);
          n_errors++;
        end else begin
          want = beats_due.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch expected=%h actual=%h", $time,
                     want.out_byte, out_data.out_byte);
            n_errors++;
          end
          if (out_data.last !== want.last) begin
            $display("%0t: last mismatch expected=%b actual=%b", $time,
                     want.last, out_data.last);
            n_errors++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (hold_req && !hold_seen) begin
        hold_left = HoldLen;
        hold_seen = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : byte_source
    int unsigned i;
    tte_in_t it;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // probes under the reset stops, every 8 columns
    for (i = 0; i < NumProbes; i++) begin
      it.in_byte  = ProbeRows[i].in_byte;
      it.new_file = ProbeRows[i].new_file;
      send_byte(it, ProbeRows[i].out_byte, ProbeRows[i].beats);
    end

    // widest uniform stop, run the column into saturation and back off it
    load_stops(3'd1, {7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd64});
    no_idle = 1'b1;
    it.in_byte  = ChTab;
    it.new_file = 1'b1;
    send_byte(it, 8'h00, 0);
    it.new_file = 1'b0;
    for (i = 0; i < 64; i++) begin
      send_byte(it, 8'h00, 0);
    end
    no_idle = 1'b0;
    it.in_byte = 8'h71;
    send_byte(it, 8'h00, 0);
    it.in_byte = ChBs;
    send_byte(it, 8'h00, 0);
    it.in_byte = ChTab;
    send_byte(it, 8'h00, 0);
    send_byte(it, 8'h00, 0);
    send_random(10);

    // narrowest width, then zero and oversized widths
    load_stops(3'd1, {7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1});
    send_random(40);
    load_stops(3'd1, {7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd0});
    send_random(30);
    load_stops(3'd1, {7'd64, 7'd2, 7'd3, 7'd4, 7'd5, 7'd127});
    send_random(40);

    // full ordered list; output held off while input keeps coming
    load_stops(3'd6, {7'd64, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5});
    send_random(20);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    send_random(30);
    no_idle  = 1'b0;
    drain();
    send_random(10);

    // count beyond the list size, unordered list with clamped entries
    load_stops(3'd7, {7'd20, 7'd127, 7'd0, 7'd50, 7'd10, 7'd30});
    send_random(50);

    load_stops(3'd2, {7'd1, 7'd1, 7'd1, 7'd1, 7'd64, 7'd3});
    send_random(40);

    for (i = 0; i < 3; i++) begin
      load_stops(3'($urandom_range(2, 5)), rand_stops());
      send_random(30);
    end

    load_stops(3'd0, rand_stops());
    send_random(50);

    drain();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tab_to_space_expander test passed");
    end else begin
      $display("tab_to_space_expander test failed");
    end
    $finish;
  end

endmodule
